[rtl/sxe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sxe_pkg;

    localparam int MAX_INDICES = 256;
    localparam int MAX_SUBSET  = 8;
    localparam int MAX_LEADS   = 1024;

    localparam int ELEM_W      = 8;
    localparam int SIZE_W      = 4;
    localparam int COUNT_W     = 9;
    localparam int SETS_W      = 19;
    localparam int MAP_AW      = $clog2(MAX_INDICES);
    localparam int LEAD_W      = $clog2(MAX_LEADS);
    localparam int TOTAL_W     = LEAD_W + 1;
    localparam int LANE_W      = $clog2(MAX_SUBSET);
    localparam int STORE_DEPTH = MAX_LEADS * MAX_SUBSET;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic REG_SUBSET_SIZE = 1'b0;
    localparam logic REG_INDEX_COUNT = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_CLR      = 11'b000_0000_0010,
        ST_OWN_RD   = 11'b000_0000_0100,
        ST_OWN_WR   = 11'b000_0000_1000,
        ST_CMP_RD   = 11'b000_0001_0000,
        ST_CMP_ACC  = 11'b000_0010_0000,
        ST_CMP_SET  = 11'b000_0100_0000,
        ST_SCAN_TOP = 11'b000_1000_0000,
        ST_SCAN_RD  = 11'b001_0000_0000,
        ST_SCAN_CHK = 11'b010_0000_0000,
        ST_EMIT     = 11'b100_0000_0000
    } state_t;

endpackage

`default_nettype wire

[rtl/subset_extension_enumerator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Subset extension enumerator.
// Input stream: s_tuser selects load (0) or fetch (1). A load writes one lead
// element (s_tdata); s_tlast closes the lead list and starts the exclusion
// map build for the first lead. A fetch returns one result on the m_ stream:
// the lead elements in order, then the extension index with m_tlast set;
// m_tuser set means nothing remains. The running set count travels in
// m_tdata above the element.
// A map build clears the map, marks the lead's own elements, then checks
// each earlier lead; the whole build runs from one memory port and one
// address unit. A fetch reads the store at the current element and emits;
// a fetch that starts a set first scans the candidates, skipping excluded
// ones, and runs a map build whenever it moves to the next lead. The block
// takes no request while it works. The result sits in an output register;
// while the receiver stalls it holds, loads are still taken, and a fetch
// waits in its last step.
// Reset (synchronous, active low) clears control state and sets subset_size
// to 1 and index_count to 256; the lead store is not cleared.
module subset_extension_enumerator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] element_index
    input  wire logic        s_tlast,   // is_last
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [7:0] out_index, [26:8] sets_emitted
    output logic             m_tlast,   // set_end
    output logic             m_tuser,   // all_done
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_wdata
);

    localparam int LW = sxe_pkg::LEAD_W;
    localparam int TW = sxe_pkg::TOTAL_W;
    localparam int SW = sxe_pkg::SIZE_W;
    localparam int CW = sxe_pkg::COUNT_W;
    localparam int EW = sxe_pkg::ELEM_W;
    localparam int MW = sxe_pkg::MAP_AW;

    sxe_pkg::state_t state_reg, state_next;

    logic [SW-1:0] size_cfg_reg, size_cfg_next;
    logic [CW-1:0] count_cfg_reg, count_cfg_next;
    logic          closed_reg, closed_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] lcur_reg, lcur_next;
    logic [CW-1:0] ccur_reg, ccur_next;
    logic [SW-1:0] ecur_reg, ecur_next;
    logic [sxe_pkg::SETS_W-1:0] sets_reg, sets_next;
    logic [LW-1:0] blead_reg, blead_next;
    logic [LW-1:0] jrow_reg, jrow_next;
    logic [SW-1:0] k_reg, k_next;
    logic [SW-1:0] same_reg, same_next;
    logic [EW-1:0] diff_reg, diff_next;
    logic [MW-1:0] clr_reg, clr_next;
    logic          ret_scan_reg, ret_scan_next;
    logic [EW-1:0] lane_reg [sxe_pkg::MAX_SUBSET];
    logic [EW-1:0] lane_next [sxe_pkg::MAX_SUBSET];

    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;
    logic          m_tlast_reg, m_tlast_next;
    logic          m_tuser_reg, m_tuser_next;

    logic [SW-1:0] n_eff;
    logic [CW-1:0] cnt_eff;
    logic          s_fire;
    logic          slot_free;

    logic [LW-1:0] a_row;
    logic [SW-1:0] a_col;
    logic [sxe_pkg::STORE_AW-1:0] st_addr;
    logic          st_we;
    logic [EW-1:0] st_rdata;

    logic          map_we;
    logic [MW-1:0] map_waddr;
    logic [0:0]    map_wdata;
    logic [0:0]    map_rdata;

    logic [TW-1:0] ld_total, ld_total_n;
    logic [SW-1:0] ld_ecur;
    logic [SW:0]   ld_ecur_inc;
    logic          lane_hit;
    logic          out_done;

    assign n_eff   = (size_cfg_reg > SW'(sxe_pkg::MAX_SUBSET)) ?
                     SW'(sxe_pkg::MAX_SUBSET) : size_cfg_reg;
    assign cnt_eff = (count_cfg_reg > CW'(sxe_pkg::MAX_INDICES)) ?
                     CW'(sxe_pkg::MAX_INDICES) : count_cfg_reg;

    assign s_tready  = (state_reg == sxe_pkg::ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // a load after the list was closed starts a fresh list
    assign ld_total    = closed_reg ? '0 : total_reg;
    assign ld_ecur     = closed_reg ? '0 : ecur_reg;
    assign ld_ecur_inc = {1'b0, ld_ecur} + 1'b1;

    always_comb begin
        ld_total_n = ld_total;
        if (ld_total < TW'(sxe_pkg::MAX_LEADS) && ld_ecur_inc >= {1'b0, n_eff}) begin
            ld_total_n = ld_total + 1'b1;
        end
    end

    always_comb begin
        lane_hit = 1'b0;
        for (int i = 0; i < sxe_pkg::MAX_SUBSET; i++) begin
            if (SW'(i) < n_eff && lane_reg[i] == st_rdata) begin
                lane_hit = 1'b1;
            end
        end
    end

    // store address select
    always_comb begin
        unique case (state_reg)
            sxe_pkg::ST_IDLE: begin
                a_row = ld_total[LW-1:0];
                a_col = ld_ecur;
            end
            sxe_pkg::ST_OWN_RD, sxe_pkg::ST_OWN_WR: begin
                a_row = blead_reg;
                a_col = k_reg;
            end
            sxe_pkg::ST_CMP_RD, sxe_pkg::ST_CMP_ACC: begin
                a_row = jrow_reg;
                a_col = k_reg;
            end
            default: begin
                a_row = lcur_reg[LW-1:0];
                a_col = ecur_reg;
            end
        endcase
    end

    assign st_we = s_fire && (s_tuser == sxe_pkg::FUNC_LOAD)
                && ld_total < TW'(sxe_pkg::MAX_LEADS) && ld_ecur < n_eff;

    sxe_addr u_addr (
        .row  (a_row),
        .col  (a_col),
        .size (n_eff),
        .addr (st_addr)
    );

    sxe_ram #(
        .WIDTH (EW),
        .DEPTH (sxe_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_addr),
        .wr_data (s_tdata),
        .rd_addr (st_addr),
        .rd_data (st_rdata)
    );

    always_comb begin
        map_we    = 1'b0;
        map_waddr = clr_reg;
        map_wdata = 1'b0;
        unique case (state_reg)
            sxe_pkg::ST_CLR: begin
                map_we = 1'b1;
            end
            sxe_pkg::ST_OWN_WR: begin
                map_we    = 1'b1;
                map_waddr = st_rdata[MW-1:0];
                map_wdata = 1'b1;
            end
            sxe_pkg::ST_CMP_SET: begin
                map_we    = (same_reg == n_eff - 1'b1);
                map_waddr = diff_reg[MW-1:0];
                map_wdata = 1'b1;
            end
            default: ;
        endcase
    end

    sxe_ram #(
        .WIDTH (1),
        .DEPTH (sxe_pkg::MAX_INDICES)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (ccur_reg[MW-1:0]),
        .rd_data (map_rdata)
    );

    assign out_done = !closed_reg || lcur_reg >= total_reg;

    always_comb begin
        state_next     = state_reg;
        size_cfg_next  = size_cfg_reg;
        count_cfg_next = count_cfg_reg;
        closed_next    = closed_reg;
        total_next     = total_reg;
        lcur_next      = lcur_reg;
        ccur_next      = ccur_reg;
        ecur_next      = ecur_reg;
        sets_next      = sets_reg;
        blead_next     = blead_reg;
        jrow_next      = jrow_reg;
        k_next         = k_reg;
        same_next      = same_reg;
        diff_next      = diff_reg;
        clr_next       = clr_reg;
        ret_scan_next  = ret_scan_reg;
        lane_next      = lane_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                sxe_pkg::REG_SUBSET_SIZE: size_cfg_next  = cfg_wdata[SW-1:0];
                sxe_pkg::REG_INDEX_COUNT: count_cfg_next = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            sxe_pkg::ST_IDLE: begin
                if (s_fire && s_tuser == sxe_pkg::FUNC_LOAD) begin
                    closed_next = 1'b0;
                    total_next  = ld_total_n;
                    ecur_next   = ld_ecur;
                    if (ld_total < TW'(sxe_pkg::MAX_LEADS)) begin
                        ecur_next = (ld_ecur_inc >= {1'b0, n_eff}) ? '0 : ld_ecur_inc[SW-1:0];
                    end
                    if (s_tlast) begin
                        closed_next = 1'b1;
                        lcur_next   = '0;
                        ccur_next   = '0;
                        ecur_next   = '0;
                        sets_next   = '0;
                        if (ld_total_n != '0) begin
                            blead_next    = '0;
                            clr_next      = '0;
                            ret_scan_next = 1'b0;
                            state_next    = sxe_pkg::ST_CLR;
                        end
                    end
                end else if (s_fire) begin
                    // read the store at the current element first
                    state_next = sxe_pkg::ST_SCAN_TOP;
                end
            end
            sxe_pkg::ST_CLR: begin
                clr_next = clr_reg + 1'b1;
                k_next   = '0;
                if (clr_reg == '1) begin
                    if (n_eff == '0) begin
                        state_next = ret_scan_reg ? sxe_pkg::ST_SCAN_RD : sxe_pkg::ST_IDLE;
                    end else begin
                        state_next = sxe_pkg::ST_OWN_RD;
                    end
                end
            end
            sxe_pkg::ST_OWN_RD: begin
                state_next = sxe_pkg::ST_OWN_WR;
            end
            sxe_pkg::ST_OWN_WR: begin
                lane_next[k_reg[sxe_pkg::LANE_W-1:0]] = st_rdata;
                if (k_reg + 1'b1 == n_eff) begin
                    k_next    = '0;
                    jrow_next = '0;
                    same_next = '0;
                    diff_next = '0;
                    if (blead_reg == '0) begin
                        state_next = ret_scan_reg ? sxe_pkg::ST_SCAN_RD : sxe_pkg::ST_IDLE;
                    end else begin
                        state_next = sxe_pkg::ST_CMP_RD;
                    end
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = sxe_pkg::ST_OWN_RD;
                end
            end
            sxe_pkg::ST_CMP_RD: begin
                state_next = sxe_pkg::ST_CMP_ACC;
            end
            sxe_pkg::ST_CMP_ACC: begin
                if (lane_hit) begin
                    same_next = same_reg + 1'b1;
                end else begin
                    diff_next = st_rdata;
                end
                if (k_reg + 1'b1 == n_eff) begin
                    state_next = sxe_pkg::ST_CMP_SET;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = sxe_pkg::ST_CMP_RD;
                end
            end
            sxe_pkg::ST_CMP_SET: begin
                jrow_next = jrow_reg + 1'b1;
                k_next    = '0;
                same_next = '0;
                diff_next = '0;
                if (jrow_reg + 1'b1 == blead_reg) begin
                    state_next = ret_scan_reg ? sxe_pkg::ST_SCAN_RD : sxe_pkg::ST_IDLE;
                end else begin
                    state_next = sxe_pkg::ST_CMP_RD;
                end
            end
            sxe_pkg::ST_SCAN_TOP: begin
                state_next = (closed_reg && ecur_reg == '0 && lcur_reg < total_reg) ?
                             sxe_pkg::ST_SCAN_RD : sxe_pkg::ST_EMIT;
            end
            sxe_pkg::ST_SCAN_RD: begin
                if (ccur_reg >= cnt_eff) begin
                    // lead exhausted: advance and rebuild the map
                    lcur_next = lcur_reg + 1'b1;
                    ccur_next = '0;
                    if (lcur_reg + 1'b1 < total_reg) begin
                        blead_next    = lcur_reg[LW-1:0] + 1'b1;
                        clr_next      = '0;
                        ret_scan_next = 1'b1;
                        state_next    = sxe_pkg::ST_CLR;
                    end else begin
                        state_next = sxe_pkg::ST_EMIT;
                    end
                end else begin
                    state_next = sxe_pkg::ST_SCAN_CHK;
                end
            end
            sxe_pkg::ST_SCAN_CHK: begin
                if (map_rdata[0]) begin
                    ccur_next  = ccur_reg + 1'b1;
                    state_next = sxe_pkg::ST_SCAN_RD;
                end else begin
                    sets_next  = sets_reg + 1'b1;
                    state_next = sxe_pkg::ST_EMIT;
                end
            end
            sxe_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = sxe_pkg::ST_IDLE;
                    if (out_done) begin
                        m_tdata_next = {5'd0, sets_reg, 8'd0};
                        m_tlast_next = 1'b0;
                        m_tuser_next = 1'b1;
                    end else if (ecur_reg < n_eff) begin
                        m_tdata_next = {5'd0, sets_reg, st_rdata};
                        m_tlast_next = 1'b0;
                        m_tuser_next = 1'b0;
                        ecur_next    = ecur_reg + 1'b1;
                    end else begin
                        m_tdata_next = {5'd0, sets_reg, ccur_reg[EW-1:0]};
                        m_tlast_next = 1'b1;
                        m_tuser_next = 1'b0;
                        ccur_next    = ccur_reg + 1'b1;
                        ecur_next    = '0;
                    end
                end
            end
            default: state_next = sxe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sxe_pkg::ST_IDLE;
            size_cfg_reg  <= SW'(1);
            count_cfg_reg <= CW'(sxe_pkg::MAX_INDICES);
            closed_reg    <= 1'b0;
            total_reg     <= '0;
            lcur_reg      <= '0;
            ccur_reg      <= '0;
            ecur_reg      <= '0;
            sets_reg      <= '0;
            ret_scan_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            size_cfg_reg  <= size_cfg_next;
            count_cfg_reg <= count_cfg_next;
            closed_reg    <= closed_next;
            total_reg     <= total_next;
            lcur_reg      <= lcur_next;
            ccur_reg      <= ccur_next;
            ecur_reg      <= ecur_next;
            sets_reg      <= sets_next;
            ret_scan_reg  <= ret_scan_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blead_reg   <= blead_next;
        jrow_reg    <= jrow_next;
        k_reg       <= k_next;
        same_reg    <= same_next;
        diff_reg    <= diff_next;
        clr_reg     <= clr_next;
        lane_reg    <= lane_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

[rtl/sxe_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sxe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/sxe_addr.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lead store address: row * subset size + column.
module sxe_addr (
    input  wire logic [sxe_pkg::LEAD_W-1:0]   row,
    input  wire logic [sxe_pkg::SIZE_W-1:0]   col,
    input  wire logic [sxe_pkg::SIZE_W-1:0]   size,
    output logic      [sxe_pkg::STORE_AW-1:0] addr
);

    logic [sxe_pkg::LEAD_W+sxe_pkg::SIZE_W:0] prod;

    always_comb begin
        prod = {{(sxe_pkg::SIZE_W + 1){1'b0}}, row}
             * {{(sxe_pkg::LEAD_W + 1){1'b0}}, size}
             + {{(sxe_pkg::LEAD_W + 1){1'b0}}, col};
        addr = prod[sxe_pkg::STORE_AW-1:0];
    end

endmodule

`default_nettype wire
